// ===== hw/rtl/ustc_pkg.sv =====
package ustc_pkg;

    localparam int NUM_STAGES = 14;
    localparam int SEARCH_STEPS = 8;

    localparam logic [11:0] BASE_YEAR = 12'd1970;
    localparam logic [7:0] LAST_YEAR_IDX = 8'd136;
    localparam logic [7:0] IDX_YEAR_2100 = 8'd130;
    localparam logic [7:0] IDX_YEAR_2101 = 8'd131;
    localparam logic [8:0] LEAP_DAY_DOY = 9'd59;

    // floor(2^32 / 675): quotient estimate low by at most one
    localparam logic [22:0] RECIP_675 = 23'd6362914;
    localparam logic [9:0] DAY_SECS_DIV128 = 10'd675;
    // ceil(2^24 / 60): exact for values below 86400
    localparam logic [18:0] RECIP_60 = 19'd279621;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } hms_t;

    // First day (counted from 1970-01-01) of year 1970 + i, for i up to 136.
    function automatic logic [15:0] year_start(input logic [7:0] i);
        logic [15:0] base;
        logic [15:0] leaps;
        base = 16'(i) * 16'd365;
        leaps = 16'((9'(i) + 9'd1) >> 2);
        if (i >= IDX_YEAR_2101) begin
            leaps = leaps - 16'd1;
        end
        return base + leaps;
    endfunction

    // Day of year on which month m begins, non-leap year.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

// ===== hw/rtl/unix_seconds_to_calendar_date.sv =====
// Unix seconds to calendar date and time of day.
//
// Input channel s_*: one 32-bit count of seconds since 1970-01-01 00:00:00
// UTC per transfer. Result channel m_*: year, month, day of month, hour,
// minute and second of that instant, one result transfer per input.
//
// The block is a 14-stage pipeline, and a new input is taken every cycle
// while the receiver does not stall. The stages: a reciprocal multiply
// splits off whole days, two reciprocal multiplies by 1/60 give the time
// of day, an 8-step binary search over the year start table finds the year,
// and three stages resolve leap day, month and day from the cumulative
// month table.
//
// Reset clears the stage valid bits only; the pipeline comes up empty.
// When a result waits with m_ready low the whole pipeline holds, and
// s_ready is low until the result is taken (s_ready = !m_valid | m_ready),
// so no transfer is lost or repeated.
module unix_seconds_to_calendar_date (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second
);
    import ustc_pkg::*;

    logic                  en;
    logic [NUM_STAGES-1:0] v_reg;

    // day split
    logic [47:0] p1_reg;
    logic [24:0] q1a_reg;
    logic [6:0]  loa_reg;
    logic [15:0] est_reg;
    logic [24:0] estm_reg;
    logic [24:0] q1b_reg;
    logic [6:0]  lob_reg;
    logic [16:0] sod_reg;

    // year search
    logic [15:0] dy_reg [2:10];
    logic [7:0]  ix_reg [2:10];
    logic [7:0]  ix_next [3:10];

    // time of day
    logic [35:0] tp_reg;
    logic [16:0] sod3_reg;
    logic [10:0] mt4_reg;
    logic [5:0]  sec4_reg;
    logic [29:0] hp_reg;
    logic [10:0] mt5_reg;
    logic [5:0]  sec5_reg;
    hms_t        tm_reg [6:NUM_STAGES-1];

    // month and day
    logic [8:0]  doy11_reg;
    logic        leap11_reg;
    logic [7:0]  ix11_reg;
    logic [8:0]  doy12_reg;
    logic [3:0]  mon12_reg;
    logic        feb29_12_reg;
    logic [7:0]  ix12_reg;
    logic [11:0] year_reg;
    logic [3:0]  mon_reg;
    logic [4:0]  day_reg;

    logic [15:0] est_c;
    logic [24:0] rem_c;
    logic [9:0]  rem_fix_c;
    logic [15:0] days_c;
    logic [10:0] mt_c;
    logic [5:0]  sec_c;
    logic [4:0]  hour_c;
    logic [5:0]  min_c;
    logic        leap_c;
    logic [8:0]  doy_c;
    logic        feb29_c;
    logic [8:0]  doy_adj_c;
    logic [3:0]  mon_c;

    assign en      = !v_reg[NUM_STAGES-1] || m_ready;
    assign s_ready = en;
    assign m_valid = v_reg[NUM_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NUM_STAGES-2:0], s_valid};
        end
    end

    always_comb begin
        est_c = p1_reg[47:32];
        rem_c = q1b_reg - estm_reg;
        if (rem_c[10:0] >= 11'(DAY_SECS_DIV128)) begin
            rem_fix_c = 10'(rem_c[10:0] - 11'(DAY_SECS_DIV128));
            days_c    = est_reg + 16'd1;
        end else begin
            rem_fix_c = rem_c[9:0];
            days_c    = est_reg;
        end
        mt_c   = tp_reg[34:24];
        sec_c  = 6'(sod3_reg - 17'(mt_c) * 17'd60);
        hour_c = hp_reg[28:24];
        min_c  = 6'(mt5_reg - 11'(hour_c) * 11'd60);
    end

    always_comb begin
        logic [7:0] cand;
        for (int k = 2; k < 2 + SEARCH_STEPS; k++) begin
            cand = ix_reg[k] | 8'(1 << (SEARCH_STEPS + 1 - k));
            if (cand <= LAST_YEAR_IDX && dy_reg[k] >= year_start(cand)) begin
                ix_next[k+1] = cand;
            end else begin
                ix_next[k+1] = ix_reg[k];
            end
        end
    end

    always_comb begin
        leap_c  = (ix_reg[10][1:0] == 2'd2) && (ix_reg[10] != IDX_YEAR_2100);
        doy_c   = 9'(dy_reg[10] - year_start(ix_reg[10]));
        feb29_c = leap11_reg && (doy11_reg == LEAP_DAY_DOY);
        doy_adj_c = (leap11_reg && doy11_reg > LEAP_DAY_DOY) ? doy11_reg - 9'd1 : doy11_reg;
        mon_c = 4'd1;
        for (int m = 1; m < 12; m++) begin
            if (doy_adj_c >= month_start(4'(m + 1))) begin
                mon_c = 4'(m + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg   <= 48'(s_epoch_seconds[31:7]) * 48'(RECIP_675);
            q1a_reg  <= s_epoch_seconds[31:7];
            loa_reg  <= s_epoch_seconds[6:0];

            est_reg  <= est_c;
            estm_reg <= 25'(est_c) * 25'(DAY_SECS_DIV128);
            q1b_reg  <= q1a_reg;
            lob_reg  <= loa_reg;

            dy_reg[2] <= days_c;
            ix_reg[2] <= 8'd0;
            sod_reg   <= {rem_fix_c, lob_reg};
            for (int k = 3; k <= 10; k++) begin
                dy_reg[k] <= dy_reg[k-1];
                ix_reg[k] <= ix_next[k];
            end

            tp_reg   <= 36'(sod_reg) * 36'(RECIP_60);
            sod3_reg <= sod_reg;
            mt4_reg  <= mt_c;
            sec4_reg <= sec_c;
            hp_reg   <= 30'(mt4_reg) * 30'(RECIP_60);
            mt5_reg  <= mt4_reg;
            sec5_reg <= sec4_reg;
            tm_reg[6] <= '{hour: hour_c, minute: min_c, second: sec5_reg};
            for (int k = 7; k < NUM_STAGES; k++) begin
                tm_reg[k] <= tm_reg[k-1];
            end

            doy11_reg  <= doy_c;
            leap11_reg <= leap_c;
            ix11_reg   <= ix_reg[10];

            doy12_reg    <= doy_adj_c;
            mon12_reg    <= mon_c;
            feb29_12_reg <= feb29_c;
            ix12_reg     <= ix11_reg;

            year_reg <= BASE_YEAR + 12'(ix12_reg);
            if (feb29_12_reg) begin
                mon_reg <= 4'd2;
                day_reg <= 5'd29;
            end else begin
                mon_reg <= mon12_reg;
                day_reg <= 5'(doy12_reg - month_start(mon12_reg) + 9'd1);
            end
        end
    end

    assign m_year         = year_reg;
    assign m_month        = mon_reg;
    assign m_day_of_month = day_reg;
    assign m_hour         = tm_reg[NUM_STAGES-1].hour;
    assign m_minute       = tm_reg[NUM_STAGES-1].minute;
    assign m_second       = tm_reg[NUM_STAGES-1].second;

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_year >= 12'd1970 && m_year <= 12'd2106 &&
                     m_month >= 4'd1 && m_month <= 4'd12 &&
                     m_day_of_month >= 5'd1 && m_day_of_month <= 5'd31))
        else $error("date field out of range");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59))
        else $error("time field out of range");

    a_feb_days: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_month == 4'd2) |-> (m_day_of_month <= 5'd29))
        else $error("February day out of range");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(v_reg))
        else $error("pipeline moved during stall");

endmodule
